@@ hdl/u8san_pkg.sv @@
// Package for the UTF-8 byte sanitizer: item types, queue job type, constants and helpers.
package u8san_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTRW  = $clog2(QDEPTH);

  localparam logic [7:0] LEAD1_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] QMARK      = 8'h3F;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;
  } out_item_t;

  // One completed run of up to four bytes, already classified.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [3:0][2:0] lens;
    logic [3:0]      cont;
    logic [2:0]      n;
    logic            fin;
  } job_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  // Sequence length announced by a lead byte; zero for an unknown form.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if ((b & LEAD1_MASK) == 8'h00) begin
      len = 3'd1;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      len = 3'd2;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      len = 3'd3;
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_CODE;
  endfunction

endpackage

@@ hdl/u8san_front.sv @@
// Front end: accepts bytes, gathers open sequences and hands finished runs to the queue.
module u8san_front import u8san_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  input  in_item_t  byte_item,
  input  q_status_t q_status,
  output logic      byte_stall,
  output logic      push,
  output job_t      push_job
);

  logic [7:0]      held [3];
  logic [2:0]      exp_len;
  logic [2:0]      exp_len_next;
  logic [1:0]      held_count;
  logic [1:0]      held_count_next;
  logic            hold_we;
  logic [1:0]      hold_idx;
  logic            accept;
  logic [2:0]      len_in;
  logic [2:0]      total;
  job_t            job;

  assign byte_stall = q_status.full;
  assign accept     = byte_valid && !q_status.full;
  assign len_in     = lead_len(byte_item.text_byte);
  assign total      = {1'b0, held_count} + 3'd1;

  always_comb begin
    job             = '0;
    push            = 1'b0;
    hold_we         = 1'b0;
    hold_idx        = 2'd0;
    exp_len_next    = exp_len;
    held_count_next = held_count;
    if (accept) begin
      if (exp_len == 3'd0) begin
        if (len_in >= 3'd2 && !byte_item.final_byte) begin
          hold_we         = 1'b1;
          hold_idx        = 2'd0;
          exp_len_next    = len_in;
          held_count_next = 2'd1;
        end else begin
          push          = 1'b1;
          job.bytes[0]  = byte_item.text_byte;
          job.n         = 3'd1;
        end
      end else begin
        if (total < exp_len && !byte_item.final_byte) begin
          hold_we         = 1'b1;
          hold_idx        = held_count;
          held_count_next = total[1:0];
        end else begin
          push = 1'b1;
          for (int j = 0; j < 3; j++) begin
            if (2'(j) < held_count) begin
              job.bytes[j] = held[j];
            end
          end
          job.bytes[held_count] = byte_item.text_byte;
          job.n                 = total;
          exp_len_next          = 3'd0;
          held_count_next       = 2'd0;
        end
      end
    end
    job.fin = byte_item.final_byte;
    for (int j = 0; j < 4; j++) begin
      job.lens[j] = lead_len(job.bytes[j]);
      job.cont[j] = is_cont(job.bytes[j]);
    end
    push_job = job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len    <= 3'd0;
      held_count <= 2'd0;
    end else begin
      exp_len    <= exp_len_next;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_we) begin
      held[hold_idx] <= byte_item.text_byte;
    end
  end

endmodule

@@ hdl/u8san_queue.sv @@
// Short job queue between the front end and the back end.
module u8san_queue import u8san_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output q_status_t q_status,
  output job_t      head
);

  job_t             slots [QDEPTH];
  logic [QPTRW-1:0] wr_ptr;
  logic [QPTRW-1:0] rd_ptr;
  logic [QPTRW:0]   count;

  assign q_status.full     = (count == (QPTRW+1)'(QDEPTH));
  assign q_status.nonempty = (count != '0);
  assign head              = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

@@ hdl/u8san_back.sv @@
// Back end: walks each run one result at a time, validating sequences and driving the output register.
module u8san_back import u8san_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_status_t q_status,
  input  job_t      head,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  job_t       work;
  logic       work_act;
  logic [2:0] pos;
  logic [1:0] pass_left;

  logic [1:0] idx;
  logic [1:0] look;
  logic [2:0] cur_len;
  logic [2:0] reach;
  logic       fits;
  logic       seq_ok;
  logic [7:0] emit_byte;
  logic [2:0] pos_next;
  logic [1:0] pass_next;
  logic       last;
  logic       adv;

  assign idx     = pos[1:0];
  assign cur_len = work.lens[idx];
  assign reach   = pos + cur_len;
  assign fits    = (cur_len != 3'd0) && (reach <= work.n);

  always_comb begin
    seq_ok = 1'b1;
    look   = idx;
    for (int j = 1; j < 4; j++) begin
      look = idx + 2'(j);
      if (3'(j) < cur_len && !work.cont[look]) begin
        seq_ok = 1'b0;
      end
    end
  end

  always_comb begin
    if (pass_left != 2'd0) begin
      emit_byte = work.bytes[idx];
      pos_next  = pos + 3'd1;
      pass_next = pass_left - 2'd1;
    end else if (!fits) begin
      emit_byte = QMARK;
      pos_next  = pos + 3'd1;
      pass_next = 2'd0;
    end else if (seq_ok) begin
      emit_byte = work.bytes[idx];
      pos_next  = pos + 3'd1;
      pass_next = 2'(cur_len - 3'd1);
    end else begin
      emit_byte = QMARK;
      pos_next  = reach;
      pass_next = 2'd0;
    end
  end

  assign last = (pos_next >= work.n);
  assign adv  = work_act && (!res_valid || !res_stall);
  assign pop  = q_status.nonempty && (!work_act || (adv && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      work_act  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        work_act <= 1'b1;
      end else if (adv && last) begin
        work_act <= 1'b0;
      end
      if (adv) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work      <= head;
      pos       <= 3'd0;
      pass_left <= 2'd0;
    end else if (adv) begin
      pos       <= pos_next;
      pass_left <= pass_next;
    end
    if (adv) begin
      res_item.out_byte <= emit_byte;
      res_item.run_end  <= last;
      res_item.text_end <= last && work.fin;
    end
  end

endmodule

@@ hdl/utf8_byte_sanitizer.sv @@
// Top level of the UTF-8 byte sanitizer: front end, job queue and back end.
//
//   Channel  Direction  Handshake             Payload
//   byte     in         byte_valid/byte_stall  byte_item (text_byte, final_byte)
//   res      out        res_valid/res_stall    res_item (out_byte, run_end, text_end)
//
// The front end takes one byte per cycle whenever the job queue has room. A byte
// that completes a sequence, or ends the text, turns into one job in the queue.
// While res_stall is low, the back end emits one result per cycle and pops the next
// job in the same cycle as the last result of the current one, so the sustained rate
// is one byte per cycle. A job goes from a queue slot to the work register to res_item.
// Reset (synchronous, active high) closes any open sequence and empties the queue.
// A stall on the result side fills the queue; byte_stall rises only when it is full.
module utf8_byte_sanitizer import u8san_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_item_t  byte_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  q_status_t q_status;
  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      head;

  // Gathers lead and continuation bytes and classifies each finished run.
  u8san_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_item  (byte_item),
    .q_status   (q_status),
    .byte_stall (byte_stall),
    .push       (push),
    .push_job   (push_job)
  );

  // Decouples the byte side from the result side.
  u8san_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_status (q_status),
    .head     (head)
  );

  // Validates each run and produces one result per transfer.
  u8san_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule
